// ===== design/ascii_melody_tone_sequencer_defines.svh =====
// ============================================================================
// ascii_melody_tone_sequencer_defines.svh - assertion macros
// Shared concurrent assertion forms used by the sequencer's checker.
// ============================================================================
`ifndef ASCII_MELODY_TONE_SEQUENCER_DEFINES_SVH
`define ASCII_MELODY_TONE_SEQUENCER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define AMTS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sequencer check failed");

// Consequent must hold in the cycle after the antecedent
`define AMTS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequencer check failed");

`endif

// ===== design/amts_pkg.sv =====
// ============================================================================
// amts_pkg - melody tone sequencer package
// Types, character codes and decode functions shared by the sequencer.
// ============================================================================
package amts_pkg;

    localparam int CHAR_W   = 8;
    localparam int PERIOD_W = 12;
    localparam int DUR_MS_W = 11;
    localparam int DUR_US_W = 21;
    localparam int PAUSE_W  = 5;
    localparam int HALF_W   = 11;
    localparam int US_W     = 10;

    localparam logic [US_W-1:0]     US_PER_MS       = 10'd1000;
    localparam logic [DUR_MS_W-1:0] LEN_STEP_MS     = 11'd200;
    localparam logic [DUR_MS_W-1:0] LEN_DEFAULT_MS  = 11'd400;
    localparam logic [DUR_US_W-1:0] LEN_STEP_US     = 21'd200000;
    localparam logic [DUR_US_W-1:0] LEN_DEFAULT_US  = 21'd400000;

    localparam logic [PAUSE_W-1:0]  GAP_NONE  = 5'd0;
    localparam logic [PAUSE_W-1:0]  GAP_SHORT = 5'd5;
    localparam logic [PAUSE_W-1:0]  GAP_MID   = 5'd20;
    localparam logic [PAUSE_W-1:0]  GAP_LONG  = 5'd30;

    localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
    localparam logic [CHAR_W-1:0] CH_UPPER_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_G  = 8'h47;
    localparam logic [CHAR_W-1:0] CH_LOWER_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_G  = 8'h67;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS     = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_COMMA    = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_UNDER    = 8'h5F;

    localparam logic [3:0] LOWER_OFFSET = 4'd7;

    localparam logic [PERIOD_W-1:0] PERIOD_TABLE [14] = '{
        12'd2272, 12'd2024, 12'd3816, 12'd3401, 12'd3030, 12'd2865, 12'd2551,
        12'd1136, 12'd1012, 12'd1912, 12'd1703, 12'd1517, 12'd1432, 12'd1275
    };

    // Decoded character or tick, as it travels from front to back
    typedef struct packed {
        logic                is_tick;
        logic                is_zero;
        logic [PERIOD_W-1:0] period;
        logic [DUR_MS_W-1:0] dur_ms;
        logic [DUR_US_W-1:0] dur_us;
        logic [PAUSE_W-1:0]  pause;
    } item_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic accepted;
    } result_t;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_TONE    = 4'b0010,
        PH_SILENCE = 4'b0100,
        PH_PAUSE   = 4'b1000
    } phase_t;

    typedef enum logic [2:0] {
        POS_NOTE = 3'b001,
        POS_LEN  = 3'b010,
        POS_GAP  = 3'b100
    } pos_t;

    function automatic logic [PERIOD_W-1:0] note_period(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] off;
        begin
            off = '0;
            note_period = '0;
            if (c >= CH_UPPER_A && c <= CH_UPPER_G) begin
                off = c - CH_UPPER_A;
                note_period = PERIOD_TABLE[off[3:0]];
            end else if (c >= CH_LOWER_A && c <= CH_LOWER_G) begin
                off = c - CH_LOWER_A;
                note_period = PERIOD_TABLE[off[3:0] + LOWER_OFFSET];
            end
        end
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        is_digit = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
    endfunction

    function automatic logic [DUR_MS_W-1:0] note_length_ms(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = c - CH_DIGIT_0;
            if (is_digit(c))
                note_length_ms = DUR_MS_W'(d[3:0]) * LEN_STEP_MS;
            else
                note_length_ms = LEN_DEFAULT_MS;
        end
    endfunction

    function automatic logic [DUR_US_W-1:0] note_length_us(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] d;
        begin
            d = c - CH_DIGIT_0;
            if (is_digit(c))
                note_length_us = DUR_US_W'(d[3:0]) * LEN_STEP_US;
            else
                note_length_us = LEN_DEFAULT_US;
        end
    endfunction

    function automatic logic [PAUSE_W-1:0] gap_length(input logic [CHAR_W-1:0] c);
        unique case (c)
            CH_PLUS:  gap_length = GAP_NONE;
            CH_COMMA: gap_length = GAP_SHORT;
            CH_DOT:   gap_length = GAP_MID;
            CH_UNDER: gap_length = GAP_LONG;
            default:  gap_length = GAP_SHORT;
        endcase
    endfunction

endpackage

// ===== design/ascii_melody_tone_sequencer.sv =====
// ============================================================================
// ascii_melody_tone_sequencer - square-wave melody sequencer
// Plays note/length/pause character records on a speaker pin against ticks.
// ============================================================================
// Every accepted item (a song character or a one-microsecond tick) returns
// exactly one result: the pin level, whether a tone, silence or pause is
// running, and whether a character was taken. One item is accepted every
// clock cycle when the output side keeps up. A result is presented after its
// item has passed through the decode register, a queue slot and the playback
// register, in that order. The accept rate is set by the playback engine,
// which updates all of its timers and the record state for one item at once.
// A stalled output fills the queue before the input side sees backpressure.
module ascii_melody_tone_sequencer
    import amts_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [CHAR_W-1:0] char_code,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              pin_level,
    output logic              busy_res,
    output logic              accepted
);

    logic    front_valid;
    logic    front_ready;
    item_t   front_item;
    logic    back_valid;
    logic    back_ready;
    item_t   back_item;
    result_t res;

    amts_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .req_type   (req_type),
        .char_code  (char_code),
        .item_valid (front_valid),
        .item_ready (front_ready),
        .item       (front_item)
    );

    amts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_item  (front_item),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready),
        .pop_item   (back_item)
    );

    amts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (back_valid),
        .item_ready (back_ready),
        .item       (back_item),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (res)
    );

    assign pin_level = res.pin_level;
    assign busy_res  = res.busy_res;
    assign accepted  = res.accepted;

endmodule

// ===== design/amts_front.sv =====
// ============================================================================
// amts_front - input stage
// Accepts ticks and characters and decodes every reading of a character.
// ============================================================================
module amts_front
    import amts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              req_type,
    input  logic [CHAR_W-1:0] char_code,
    output logic              item_valid,
    input  logic              item_ready,
    output item_t             item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    item_t item_next;
    logic  take;

    assign in_ready   = !valid_reg || item_ready;
    assign take       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        item_next.is_tick = req_type;
        item_next.is_zero = (char_code == CH_NUL);
        item_next.period  = note_period(char_code);
        item_next.dur_ms  = note_length_ms(char_code);
        item_next.dur_us  = note_length_us(char_code);
        item_next.pause   = gap_length(char_code);
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = 1'b1;
        else if (item_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_next;
    end

endmodule

// ===== design/amts_queue.sv =====
// ============================================================================
// amts_queue - decoupling queue
// Small FIFO of decoded items between the front and the back (DEPTH >= 2).
// ============================================================================
module amts_queue
    import amts_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);

    item_t             slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              push;
    logic              pop;

    assign push_ready = (count_reg != FULL);
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_item   = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== design/amts_back.sv =====
// ============================================================================
// amts_back - playback engine
// Applies one decoded item a cycle to the record and tone state while its result is taken.
// ============================================================================
module amts_back
    import amts_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_ready,
    input  item_t   item,
    output logic    res_valid,
    input  logic    res_ready,
    output result_t res
);

    pos_t                pos_reg,      pos_next;
    phase_t              phase_reg,    phase_next;
    logic [PERIOD_W-1:0] period_reg,   period_next;
    logic [DUR_MS_W-1:0] dur_ms_reg,   dur_ms_next;
    logic [DUR_US_W-1:0] dur_us_reg,   dur_us_next;
    logic [PAUSE_W-1:0]  pause_reg,    pause_next;
    logic [HALF_W-1:0]   half_cnt_reg, half_cnt_next;
    logic [DUR_US_W-1:0] elapsed_reg,  elapsed_next;
    logic [US_W-1:0]     us_reg,       us_next;
    logic [DUR_MS_W-1:0] ms_reg,       ms_next;
    logic                pin_reg,      pin_next;
    logic                res_valid_reg, res_valid_next;
    result_t             res_reg;

    logic                pop;
    logic                acc;
    logic [US_W-1:0]     us_inc;
    logic [DUR_MS_W-1:0] ms_inc;
    logic [HALF_W-1:0]   half_inc;
    logic [DUR_US_W-1:0] elapsed_sum;
    phase_t              after_sound;

    assign item_ready = !res_valid_reg || res_ready;
    assign pop        = item_valid && item_ready;
    assign res_valid  = res_valid_reg;
    assign res        = res_reg;

    always_comb
    begin
        pos_next      = pos_reg;
        phase_next    = phase_reg;
        period_next   = period_reg;
        dur_ms_next   = dur_ms_reg;
        dur_us_next   = dur_us_reg;
        pause_next    = pause_reg;
        half_cnt_next = half_cnt_reg;
        elapsed_next  = elapsed_reg;
        us_next       = us_reg;
        ms_next       = ms_reg;
        pin_next      = pin_reg;
        acc           = 1'b0;

        // millisecond timer step
        us_inc = us_reg + 1'b1;
        ms_inc = ms_reg;
        if (us_inc >= US_PER_MS)
        begin
            us_inc = '0;
            ms_inc = ms_reg + 1'b1;
        end

        half_inc    = half_cnt_reg + 1'b1;
        elapsed_sum = elapsed_reg + DUR_US_W'(period_reg);
        after_sound = (pause_reg != '0) ? PH_PAUSE : PH_IDLE;

        if (pop)
        begin
            if (item.is_tick)
            begin
                unique case (phase_reg)
                    PH_TONE:
                    begin
                        if (half_inc >= period_reg[PERIOD_W-1:1])
                        begin
                            half_cnt_next = '0;
                            if (pin_reg)
                                pin_next = 1'b0;
                            else
                            begin
                                elapsed_next = elapsed_sum;
                                if (elapsed_sum < dur_us_reg)
                                    pin_next = 1'b1;
                                else
                                begin
                                    us_next    = '0;
                                    ms_next    = '0;
                                    phase_next = after_sound;
                                end
                            end
                        end
                        else
                            half_cnt_next = half_inc;
                    end
                    PH_SILENCE:
                    begin
                        us_next = us_inc;
                        ms_next = ms_inc;
                        if (ms_inc >= dur_ms_reg)
                        begin
                            pin_next   = 1'b0;
                            us_next    = '0;
                            ms_next    = '0;
                            phase_next = after_sound;
                        end
                    end
                    PH_PAUSE:
                    begin
                        us_next = us_inc;
                        ms_next = ms_inc;
                        if (ms_inc >= DUR_MS_W'(pause_reg))
                            phase_next = PH_IDLE;
                    end
                    PH_IDLE:
                    begin
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (phase_reg == PH_IDLE)
            begin
                acc = 1'b1;
                if (item.is_zero)
                    pos_next = POS_NOTE;
                else
                begin
                    unique case (pos_reg)
                        POS_LEN:
                        begin
                            dur_ms_next = item.dur_ms;
                            dur_us_next = item.dur_us;
                            pos_next    = POS_GAP;
                        end
                        POS_GAP:
                        begin
                            // record complete: start the sound, or for a zero length the pause if any
                            pause_next    = item.pause;
                            pos_next      = POS_NOTE;
                            half_cnt_next = '0;
                            elapsed_next  = '0;
                            us_next       = '0;
                            ms_next       = '0;
                            if (dur_ms_reg == '0)
                            begin
                                pin_next   = 1'b0;
                                phase_next = (item.pause != '0) ? PH_PAUSE : PH_IDLE;
                            end
                            else if (period_reg != '0)
                            begin
                                pin_next   = 1'b1;
                                phase_next = PH_TONE;
                            end
                            else
                            begin
                                pin_next   = 1'b0;
                                phase_next = PH_SILENCE;
                            end
                        end
                        default:
                        begin
                            period_next = item.period;
                            pos_next    = POS_LEN;
                        end
                    endcase
                end
            end
        end

        res_valid_next = res_valid_reg;
        if (pop)
            res_valid_next = 1'b1;
        else if (res_ready)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_NOTE;
            phase_reg     <= PH_IDLE;
            period_reg    <= '0;
            dur_ms_reg    <= '0;
            dur_us_reg    <= '0;
            pause_reg     <= '0;
            half_cnt_reg  <= '0;
            elapsed_reg   <= '0;
            us_reg        <= '0;
            ms_reg        <= '0;
            pin_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            phase_reg     <= phase_next;
            period_reg    <= period_next;
            dur_ms_reg    <= dur_ms_next;
            dur_us_reg    <= dur_us_next;
            pause_reg     <= pause_next;
            half_cnt_reg  <= half_cnt_next;
            elapsed_reg   <= elapsed_next;
            us_reg        <= us_next;
            ms_reg        <= ms_next;
            pin_reg       <= pin_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            res_reg.pin_level <= pin_next;
            res_reg.busy_res  <= (phase_next != PH_IDLE);
            res_reg.accepted  <= acc;
        end
    end

endmodule

// ===== design/amts_checker.sv =====
// ============================================================================
// amts_checker - port-level checks
// Watches the sequencer's ports and flags broken output behaviour.
// ============================================================================
`include "ascii_melody_tone_sequencer_defines.svh"

module amts_checker
(
    input logic clk,
    input logic rst_n,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic pin_level,
    input logic busy_res,
    input logic accepted
);

    logic [2:0] out_fields;

    assign out_fields = {pin_level, busy_res, accepted};

    // hold a stalled result
    `AMTS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_fields))

    // a high pin is only reported while the sequencer is busy
    `AMTS_ASSERT_NOW(a_pin_busy, out_valid && pin_level, busy_res)

    // input stalls only behind a waiting result
    `AMTS_ASSERT_NOW(a_stall_cause, !in_ready, out_valid)

endmodule

bind ascii_melody_tone_sequencer amts_checker u_amts_checker (.*);

// ===== tb/sv/tone_sequencer_checker.sv =====
`timescale 1ns / 100ps
// ============================================================================
// tone_sequencer_checker - result checker for the melody tone sequencer
// Watches both channels, predicts the result of every accepted transaction
// from its own model of the record, playback and timer state, and compares
// each returned result field by field with the oldest prediction.
// ============================================================================
module tone_sequencer_checker
    import amts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              req_type,
    input  logic [CHAR_W-1:0] char_code,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic              pin_level,
    input  logic              busy_res,
    input  logic              accepted,
    output int                fail_count,
    output int                pending_count,
    output logic              song_busy
);

    localparam int unsigned MS_TO_US          = 1000;
    localparam int unsigned LENGTH_STEP_MS    = 200;
    localparam int unsigned LENGTH_DEFAULT_MS = 400;
    localparam int          REPORT_LIMIT      = 10;

    // Predicted block state
    pos_t                record_slot;
    logic [PERIOD_W-1:0] note_period_us;
    logic [DUR_MS_W-1:0] note_dur_ms;
    logic [PAUSE_W-1:0]  rest_ms;
    phase_t              play_state;
    logic [HALF_W-1:0]   half_ticks;
    logic [DUR_US_W-1:0] played_us;
    logic [US_W-1:0]     timer_us;
    logic [DUR_MS_W-1:0] timer_ms;
    logic                speaker;

    result_t expected_results [$];
    int      result_index;

    function automatic logic [PERIOD_W-1:0] period_for(input logic [CHAR_W-1:0] ch);
        int idx;
        begin
            idx = -1;
            if (ch >= CH_UPPER_A && ch <= CH_UPPER_G)
                idx = int'(ch - CH_UPPER_A);
            else if (ch >= CH_LOWER_A && ch <= CH_LOWER_G)
                idx = int'(ch - CH_LOWER_A) + 7;
            case (idx)
                0:       period_for = 12'd2272;
                1:       period_for = 12'd2024;
                2:       period_for = 12'd3816;
                3:       period_for = 12'd3401;
                4:       period_for = 12'd3030;
                5:       period_for = 12'd2865;
                6:       period_for = 12'd2551;
                7:       period_for = 12'd1136;
                8:       period_for = 12'd1012;
                9:       period_for = 12'd1912;
                10:      period_for = 12'd1703;
                11:      period_for = 12'd1517;
                12:      period_for = 12'd1432;
                13:      period_for = 12'd1275;
                default: period_for = '0;
            endcase
        end
    endfunction

    function automatic logic [DUR_MS_W-1:0] length_for(input logic [CHAR_W-1:0] ch);
        if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9)
            length_for = DUR_MS_W'(int'(ch - CH_DIGIT_0) * LENGTH_STEP_MS);
        else
            length_for = DUR_MS_W'(LENGTH_DEFAULT_MS);
    endfunction

    function automatic logic [PAUSE_W-1:0] rest_for(input logic [CHAR_W-1:0] ch);
        case (ch)
            CH_PLUS:  rest_for = 5'd0;
            CH_COMMA: rest_for = 5'd5;
            CH_DOT:   rest_for = 5'd20;
            CH_UNDER: rest_for = 5'd30;
            default:  rest_for = 5'd5;
        endcase
    endfunction

    function automatic void enter_rest();
        speaker    = 1'b0;
        timer_us   = '0;
        timer_ms   = '0;
        play_state = (rest_ms != '0) ? PH_PAUSE : PH_IDLE;
    endfunction

    function automatic void enter_record();
        half_ticks = '0;
        played_us  = '0;
        timer_us   = '0;
        timer_ms   = '0;
        if (note_dur_ms == '0)
            enter_rest();
        else if (note_period_us != '0)
        begin
            play_state = PH_TONE;
            speaker    = 1'b1;
        end
        else
        begin
            play_state = PH_SILENCE;
            speaker    = 1'b0;
        end
    endfunction

    // Advance the millisecond timer by one microsecond; true once target is reached
    function automatic logic timer_reached(input int unsigned target);
        timer_us = timer_us + 1'b1;
        if (timer_us >= US_W'(MS_TO_US))
        begin
            timer_us = '0;
            timer_ms = timer_ms + 1'b1;
        end
        return 32'(timer_ms) >= target;
    endfunction

    function automatic void tick_once();
        logic [PERIOD_W-1:0] half;
        begin
            half = note_period_us >> 1;
            case (play_state)
                PH_TONE:
                begin
                    half_ticks = half_ticks + 1'b1;
                    if (PERIOD_W'(half_ticks) >= half)
                    begin
                        half_ticks = '0;
                        if (speaker)
                            speaker = 1'b0;
                        else
                        begin
                            played_us = played_us + DUR_US_W'(note_period_us);
                            if (32'(played_us) < 32'(note_dur_ms) * MS_TO_US)
                                speaker = 1'b1;
                            else
                                enter_rest();
                        end
                    end
                end
                PH_SILENCE:
                    if (timer_reached(32'(note_dur_ms)))
                        enter_rest();
                PH_PAUSE:
                    if (timer_reached(32'(rest_ms)))
                        play_state = PH_IDLE;
                default:
                begin
                end
            endcase
        end
    endfunction

    function automatic logic take_char(input logic [CHAR_W-1:0] ch);
        if (play_state != PH_IDLE)
            return 1'b0;
        if (ch == CH_NUL)
        begin
            record_slot = POS_NOTE;
            return 1'b1;
        end
        case (record_slot)
            POS_LEN:
            begin
                note_dur_ms = length_for(ch);
                record_slot = POS_GAP;
            end
            POS_GAP:
            begin
                rest_ms     = rest_for(ch);
                record_slot = POS_NOTE;
                enter_record();
            end
            default:
            begin
                note_period_us = period_for(ch);
                record_slot    = POS_LEN;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic result_t play_item(input logic is_tick, input logic [CHAR_W-1:0] ch);
        result_t r;
        begin
            r.accepted = 1'b0;
            if (is_tick)
                tick_once();
            else
                r.accepted = take_char(ch);
            r.pin_level = speaker;
            r.busy_res  = (play_state != PH_IDLE);
            return r;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            record_slot    = POS_NOTE;
            note_period_us = '0;
            note_dur_ms    = '0;
            rest_ms        = '0;
            play_state     = PH_IDLE;
            half_ticks     = '0;
            played_us      = '0;
            timer_us       = '0;
            timer_ms       = '0;
            speaker        = 1'b0;
            expected_results.delete();
            result_index   = 0;
            fail_count     = 0;
            pending_count  = 0;
            song_busy      = 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: result %0d arrived with nothing outstanding",
                                 $realtime, result_index);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (pin_level !== want.pin_level || busy_res !== want.busy_res ||
                        accepted !== want.accepted)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"%0t: result %0d differs: expected pin=%0b busy=%0b ",
                                      "acc=%0b, got pin=%0b busy=%0b acc=%0b"},
                                     $realtime, result_index, want.pin_level,
                                     want.busy_res, want.accepted, pin_level, busy_res,
                                     accepted);
                    end
                end
                result_index++;
            end
            if (in_valid && in_ready)
                expected_results.push_back(play_item(req_type, char_code));
            pending_count = expected_results.size();
            song_busy     = (play_state != PH_IDLE);
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ============================================================================
// testbench - melody tone sequencer testbench
// Feeds song characters and microsecond ticks with random gaps and output
// stalls, then starts a tone and plays part of it, and reports the verdict
// from the checker's failure and pending counts.
// ============================================================================
module testbench;
    import amts_pkg::*;

    localparam logic KIND_CHAR        = 1'b0;
    localparam logic KIND_TICK        = 1'b1;
    localparam int   RANDOM_END       = 260;
    localparam int   TONE_TICKS       = 540;
    localparam int   LONG_HOLD_CYCLES = 300;
    localparam int   STALL_LIMIT      = 3000;
    localparam int   DRAIN_CYCLES     = 10;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    logic              req_type;
    logic [CHAR_W-1:0] char_code;
    logic              out_valid;
    logic              out_ready;
    logic              pin_level;
    logic              busy_res;
    logic              accepted;

    int   fail_count;
    int   pending_count;
    logic song_busy;

    bit   long_hold_req = 1'b0;
    int   items_sent;
    int   quiet_cycles;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    ascii_melody_tone_sequencer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .char_code (char_code),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .pin_level (pin_level),
        .busy_res  (busy_res),
        .accepted  (accepted)
    );

    tone_sequencer_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .char_code     (char_code),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pin_level     (pin_level),
        .busy_res      (busy_res),
        .accepted      (accepted),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .song_busy     (song_busy)
    );

    function automatic int sender_gap();
        int r;
        begin
            r = $urandom_range(0, 99);
            if (r < 93)
                return 0;
            else if (r < 99)
                return $urandom_range(1, 3);
            return $urandom_range(8, 40);
        end
    endfunction

    function automatic logic [CHAR_W-1:0] random_note();
        int r;
        begin
            if ($urandom_range(0, 9) < 4)
                return CHAR_W'($urandom_range(1, 255));
            r = $urandom_range(0, 13);
            if (r < 7)
                return CH_UPPER_A + CHAR_W'(r);
            return CH_LOWER_A + CHAR_W'(r - 7);
        end
    endfunction

    // Entered at a falling edge; returns at the falling edge after the transaction
    task automatic send_item(input logic kind, input logic [CHAR_W-1:0] ch);
        int gap;
        begin
            gap = sender_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid  <= 1'b1;
            req_type  <= kind;
            char_code <= ch;
            do
                @(posedge clk);
            while (!in_ready);
            items_sent++;
            @(negedge clk);
        end
    endtask

    task automatic send_record(input logic [CHAR_W-1:0] note, input logic [CHAR_W-1:0] len,
                               input logic [CHAR_W-1:0] rest);
        send_item(KIND_CHAR, note);
        send_item(KIND_CHAR, len);
        send_item(KIND_CHAR, rest);
    endtask

    // Send a fixed number of items, mostly ticks, with the odd character mixed in
    task automatic play_ticks(input int count, input int noise_per_mille);
        repeat (count)
        begin
            if ($urandom_range(0, 999) < noise_per_mille)
                send_item(KIND_CHAR, CHAR_W'($urandom_range(0, 255)));
            else
                send_item(KIND_TICK, CHAR_W'($urandom_range(0, 255)));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
    endtask

    // Receiver: short random stalls, and one long hold-off when asked
    initial
    begin
        int stall_left;
        out_ready  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if ($urandom_range(0, 99) < 5)
            begin
                if ($urandom_range(0, 4) == 0)
                    stall_left = $urandom_range(6, 30) - 1;
                else
                    stall_left = $urandom_range(1, 3) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: end the run if nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int kind;
        int episodes;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = KIND_CHAR;
        char_code  = '0;
        items_sent = 0;
        episodes   = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Ticks while idle change nothing
        send_item(KIND_TICK, 8'h00);
        send_item(KIND_TICK, 8'hFF);
        send_item(KIND_CHAR, CH_NUL);
        // Drop partial records
        send_item(KIND_CHAR, CH_UPPER_A);
        send_item(KIND_CHAR, "5");
        send_item(KIND_CHAR, CH_NUL);
        send_item(KIND_CHAR, CH_UPPER_G);
        send_item(KIND_CHAR, CH_NUL);
        send_item(KIND_CHAR, CH_LOWER_A);
        send_item(KIND_CHAR, CH_DIGIT_9);
        send_item(KIND_CHAR, CH_NUL);
        // Zero length and no pause: nothing to play
        send_record("C", CH_DIGIT_0, CH_PLUS);
        send_item(KIND_TICK, 8'h55);

        // Hold the output off while the sender keeps offering, to fill the block
        long_hold_req = 1'b1;
        while (items_sent < RANDOM_END)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                repeat ($urandom_range(1, 5))
                    send_item(KIND_TICK, CHAR_W'($urandom_range(0, 255)));
            end
            else if (kind < 25)
                send_item(KIND_CHAR, CH_NUL);
            else if (kind < 45)
            begin
                send_item(KIND_CHAR, random_note());
                if ($urandom_range(0, 1) == 1)
                    send_item(KIND_CHAR, CHAR_W'($urandom_range(1, 255)));
                send_item(KIND_CHAR, CH_NUL);
            end
            else
            begin
                send_record(random_note(), CH_DIGIT_0, CH_PLUS);
                send_item(KIND_TICK, CHAR_W'($urandom_range(0, 255)));
            end
            episodes++;
            if (episodes % 16 == 0)
                wait_drained();
        end
        wait_drained();

        // Start a tone on the shortest period and play past its first high half,
        // slipping in characters that must be refused
        send_record("b", "1", CH_PLUS);
        play_ticks(TONE_TICKS, 20);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
